// File: design/backslash_escape_decoder_core_defines.svh
// Assertion macros for the escape decoder. They expect clk and arst_n in scope.
`ifndef BACKSLASH_ESCAPE_DECODER_CORE_DEFINES_SVH
`define BACKSLASH_ESCAPE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BED_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bed_pkg.sv
`timescale 1ns / 1ps

package bed_pkg;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_TRAIL   = 3'd1,
		ERR_UNKNOWN = 3'd2,
		ERR_TRUNC   = 3'd3,
		ERR_BADHEX  = 3'd4
	} err_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] BYTE_LF   = 8'h0A;
	localparam logic [7:0] BYTE_CR   = 8'h0D;
	localparam logic [7:0] BYTE_TAB  = 8'h09;
	localparam logic [7:0] BYTE_NUL  = 8'h00;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Strict hex digit: 0-9, A-F, a-f only.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b0;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h.ok  = 1'b1;
			h.val = 4'(c[2:0] + 3'd1) + 4'd8;
		end
		return h;
	endfunction

endpackage

// File: design/bed_if.sv
`timescale 1ns / 1ps

interface bed_in_if
	import bed_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface bed_out_if
	import bed_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	err_t       out_error;
	logic       out_end;

	modport source (output valid, output out_byte, output out_valid, output out_error,
		output out_end, input ready);
	modport sink   (input valid, input out_byte, input out_valid, input out_error,
		input out_end, output ready);
endinterface

// File: design/backslash_escape_decoder_core.sv
// Streaming backslash-escape decoder. Each byte item on din (with in_last marking the
// end of a stream) yields exactly one result item on dout: a decoded byte with
// out_valid set, an error code, or an empty result while an escape is still being
// collected. Escapes are \\, \n, \r, \t, \0 and \xHH with strict hex digits. After an
// error, results stay empty until the last item of the stream, which returns the
// block to idle. An item is held in the input register and then moves into the result
// register, from which it shows on dout; both stages advance together, so one item is
// taken per cycle while dout is not stalled. A result leaves at the first edge with
// dout ready; a stalled dout holds both stages.
`timescale 1ns / 1ps
`include "backslash_escape_decoder_core_defines.svh"

module backslash_escape_decoder_core
	import bed_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bed_in_if.sink    din,
	bed_out_if.source dout
);

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_ESC    = 2'd1,
		PH_HEX1   = 2'd2,
		PH_HEX2   = 2'd3
	} phase_t;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	phase_t     phase_q, phase_d;
	logic [3:0] nib_q, nib_d;
	logic       fbad_q, fbad_d;
	logic       hold_q, hold_d;

	logic       ovld_q;
	logic [7:0] obyte_q, obyte_d;
	logic       oval_q, oval_d;
	err_t       oerr_q, oerr_d;
	logic       oend_q;

	logic       adv;
	hex_t       hx;

	// Result register frees up when empty or being taken.
	assign adv       = !ovld_q || dout.ready;
	assign din.ready = !v_s1 || adv;

	assign hx = hex_decode(byte_s1);

	always_comb begin
		phase_d = phase_q;
		nib_d   = nib_q;
		fbad_d  = fbad_q;
		hold_d  = hold_q;
		obyte_d = 8'd0;
		oval_d  = 1'b0;
		oerr_d  = ERR_NONE;
		if (!hold_q) begin
			unique case (phase_q)
				PH_NORMAL: begin
					if (byte_s1 == CH_BSLASH) begin
						if (last_s1) oerr_d = ERR_TRAIL;
						else phase_d = PH_ESC;
					end else begin
						obyte_d = byte_s1;
						oval_d  = 1'b1;
					end
				end
				PH_ESC: begin
					phase_d = PH_NORMAL;
					unique case (byte_s1)
						CH_BSLASH: begin obyte_d = CH_BSLASH; oval_d = 1'b1; end
						CH_N:      begin obyte_d = BYTE_LF;   oval_d = 1'b1; end
						CH_R:      begin obyte_d = BYTE_CR;   oval_d = 1'b1; end
						CH_T:      begin obyte_d = BYTE_TAB;  oval_d = 1'b1; end
						CH_ZERO:   begin obyte_d = BYTE_NUL;  oval_d = 1'b1; end
						CH_X: begin
							if (last_s1) oerr_d = ERR_TRUNC;
							else phase_d = PH_HEX1;
						end
						default: oerr_d = ERR_UNKNOWN;
					endcase
				end
				PH_HEX1: begin
					if (last_s1) begin
						oerr_d = ERR_TRUNC;
					end else begin
						fbad_d  = !hx.ok;
						nib_d   = hx.val;
						phase_d = PH_HEX2;
					end
				end
				PH_HEX2: begin
					phase_d = PH_NORMAL;
					if (!hx.ok || fbad_q) begin
						oerr_d = ERR_BADHEX;
					end else begin
						obyte_d = {nib_q, hx.val};
						oval_d  = 1'b1;
					end
					nib_d  = 4'd0;
					fbad_d = 1'b0;
				end
				default: phase_d = PH_NORMAL;
			endcase
		end
		if (oerr_d != ERR_NONE) begin
			hold_d  = 1'b1;
			phase_d = PH_NORMAL;
		end
		// End of stream: back to idle.
		if (last_s1) begin
			phase_d = PH_NORMAL;
			nib_d   = 4'd0;
			fbad_d  = 1'b0;
			hold_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			ovld_q  <= 1'b0;
			phase_q <= PH_NORMAL;
			nib_q   <= 4'd0;
			fbad_q  <= 1'b0;
			hold_q  <= 1'b0;
		end else begin
			if (din.ready) begin
				v_s1 <= din.valid;
			end
			if (adv) begin
				ovld_q <= v_s1;
				if (v_s1) begin
					phase_q <= phase_d;
					nib_q   <= nib_d;
					fbad_q  <= fbad_d;
					hold_q  <= hold_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			byte_s1 <= din.in_byte;
			last_s1 <= din.in_last;
		end
		if (adv && v_s1) begin
			obyte_q <= obyte_d;
			oval_q  <= oval_d;
			oerr_q  <= oerr_d;
			oend_q  <= last_s1;
		end
	end

	assign dout.valid     = ovld_q;
	assign dout.out_byte  = obyte_q;
	assign dout.out_valid = oval_q;
	assign dout.out_error = oerr_q;
	assign dout.out_end   = oend_q;

	`BED_ASSERT_NOW(a_err_no_byte, dout.valid && dout.out_error != ERR_NONE,
		!dout.out_valid && dout.out_byte == 8'd0, "error result carries a byte")
	`BED_ASSERT_NEXT(a_end_idle, adv && v_s1 && last_s1,
		phase_q == PH_NORMAL && !hold_q && !fbad_q && nib_q == 4'd0,
		"state not cleared at end of stream")
	`BED_ASSERT_NOW(a_hold_normal, hold_q, phase_q == PH_NORMAL,
		"escape pending while suppressing")
	`BED_ASSERT_NOW(a_nib_in_hex2, fbad_q || nib_q != 4'd0, phase_q == PH_HEX2,
		"held nibble outside second hex digit")
	`BED_ASSERT_NEXT(a_item_moves, adv && v_s1, dout.valid,
		"item lost between input and result register")

endmodule
